// File: hw/rtl/ffsa_pkg.sv
// Shared constants for the first-fit slot allocator.
package ffsa_pkg;

  localparam int POOL_SIZE_DEF = 2048;

  // Bitmap memory word width and the fixed request field widths.
  localparam int WORD_W = 32;
  localparam int SLOT_W = 11;
  localparam int LEN_W  = 12;
  localparam int FREE_W = 12;

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

endpackage

// File: hw/rtl/first_fit_slot_allocator.sv
// First-fit contiguous slot allocator over a word-wide used-mark bitmap memory.
// Allocate: word 0 is read in idle, then the scan takes one bitmap word a cycle up to the word where
//   the run ends, then a read-modify-write pass over the words the run spans, then the reply.
// Release: the same read-modify-write pass, then the reply; a rejected request goes straight to the reply.
// One request is in work at a time; the bitmap memory reads one word and writes one word a cycle.
// Reset clears the bitmap by a pass of one word a cycle; in_ready is low.
module first_fit_slot_allocator #(
  parameter int POOL_SIZE = ffsa_pkg::POOL_SIZE_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_operation,
  input  logic [ffsa_pkg::SLOT_W-1:0] in_slot_index,
  input  logic [ffsa_pkg::LEN_W-1:0]  in_run_length,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_success,
  output logic [ffsa_pkg::SLOT_W-1:0] out_start_slot,
  output logic [ffsa_pkg::FREE_W-1:0] out_free_slots
);

  localparam int WW    = ffsa_pkg::WORD_W;
  localparam int WB    = $clog2(WW);
  localparam int CNTW  = $clog2(WW + 1);
  localparam int WORDS = (POOL_SIZE + WW - 1) / WW;
  localparam int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int PW    = WAW + WB;
  localparam int CW    = $clog2(POOL_SIZE + 1);
  localparam int LW    = (CW > ffsa_pkg::LEN_W) ? CW : ffsa_pkg::LEN_W;
  localparam int XW    = ((PW > LW) ? PW : LW) + 1;
  localparam int TAIL  = WORDS * WW - POOL_SIZE;

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_SCAN   = 6'b000100,
    ST_UPD_RD = 6'b001000,
    ST_UPD_WR = 6'b010000,
    ST_DONE   = 6'b100000
  } state_t;

  // Free bits in w that end at bit i (the whole prefix when nothing below is used).
  function automatic logic [CNTW-1:0] run_at(input logic [WW-1:0] w, input int i);
    logic [CNTW-1:0] r;
    r = CNTW'(i + 1);
    for (int j = 0; j < WW; j++) begin
      if (j <= i && w[j]) begin
        r = CNTW'(i - j);
      end
    end
    return r;
  endfunction

  function automatic logic [CNTW-1:0] popcount(input logic [WW-1:0] w);
    logic [CNTW-1:0] c;
    c = '0;
    for (int j = 0; j < WW; j++) begin
      c = c + CNTW'(w[j]);
    end
    return c;
  endfunction

  logic [WW-1:0]  mem [WORDS];
  logic [WW-1:0]  rdata_r;
  logic [WAW-1:0] rd_addr;
  logic           we;
  logic [WAW-1:0] wa;
  logic [WW-1:0]  wd;

  state_t         state_r, state_nxt;
  logic [WAW-1:0] clr_idx_r, clr_idx_nxt;
  logic [WAW-1:0] scan_idx_r, scan_idx_nxt;
  logic [WAW-1:0] upd_idx_r, upd_idx_nxt;
  logic           op_r, op_nxt;
  logic [LW-1:0]  len_r, len_nxt;
  logic [LW-1:0]  carry_r, carry_nxt;
  logic [PW-1:0]  lo_r, lo_nxt;
  logic [PW-1:0]  hi_r, hi_nxt;
  logic           ok_r, ok_nxt;
  logic [PW-1:0]  start_r, start_nxt;
  logic [CW-1:0]  free_r, free_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic           out_ok_r, out_ok_nxt;
  logic [PW-1:0]  out_start_r, out_start_nxt;
  logic [CW-1:0]  out_free_r, out_free_nxt;

  logic [WW-1:0]   scan_w;
  logic [WW-1:0]   hit;
  logic [WB-1:0]   hit_pos;
  logic [LW-1:0]   scan_carry;
  logic [CNTW-1:0] runw [WW];
  logic [LW-1:0]   run_i;
  logic [WW-1:0]   upd_mask;
  logic [WW-1:0]   ones;
  logic            accept;
  logic [XW-1:0]   rel_end;
  logic [PW+ffsa_pkg::SLOT_W-1:0] start_ext;
  logic [CW+ffsa_pkg::FREE_W-1:0] free_ext;

  assign ones     = '1;
  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign rel_end  = XW'(in_slot_index) + XW'(in_run_length);

  // Scan of one bitmap word: slots past the pool's end read as used.
  always_comb begin
    scan_w = rdata_r;
    if (TAIL > 0 && scan_idx_r == WAW'(WORDS - 1)) begin
      scan_w = rdata_r | ~(ones >> TAIL);
    end
    hit = '0;
    for (int i = 0; i < WW; i++) begin
      runw[i] = run_at(scan_w, i);
      if (runw[i] == CNTW'(i + 1)) begin
        run_i = carry_r + LW'(i + 1);
      end else begin
        run_i = LW'(runw[i]);
      end
      hit[i] = (run_i >= len_r);
    end
    hit_pos = '0;
    for (int i = WW - 1; i >= 0; i--) begin
      if (hit[i]) begin
        hit_pos = WB'(i);
      end
    end
    if (scan_w == '0) begin
      scan_carry = carry_r + LW'(WW);
    end else begin
      scan_carry = LW'(runw[WW-1]);
    end
  end

  // Bits of the current update word that lie inside [lo, hi].
  always_comb begin
    upd_mask = ones;
    if (upd_idx_r == lo_r[PW-1:WB]) begin
      upd_mask = upd_mask & (ones << lo_r[WB-1:0]);
    end
    if (upd_idx_r == hi_r[PW-1:WB]) begin
      upd_mask = upd_mask & (ones >> (WB'(WW - 1) - hi_r[WB-1:0]));
    end
  end

  always_comb begin
    state_nxt     = state_r;
    clr_idx_nxt   = clr_idx_r;
    scan_idx_nxt  = scan_idx_r;
    upd_idx_nxt   = upd_idx_r;
    op_nxt        = op_r;
    len_nxt       = len_r;
    carry_nxt     = carry_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    ok_nxt        = ok_r;
    start_nxt     = start_r;
    free_nxt      = free_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_ok_nxt    = out_ok_r;
    out_start_nxt = out_start_r;
    out_free_nxt  = out_free_r;
    rd_addr       = '0;
    we            = 1'b0;
    wa            = upd_idx_r;
    wd            = rdata_r;

    case (state_r)
      ST_CLEAR: begin
        we          = 1'b1;
        wa          = clr_idx_r;
        wd          = '0;
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == WAW'(WORDS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        // Word 0 is read here so that the scan can start on the next cycle.
        rd_addr = '0;
        if (accept) begin
          op_nxt       = in_operation;
          len_nxt      = LW'(in_run_length);
          ok_nxt       = 1'b0;
          start_nxt    = '0;
          carry_nxt    = '0;
          scan_idx_nxt = '0;
          lo_nxt       = PW'(in_slot_index);
          hi_nxt       = PW'(rel_end - XW'(1));
          if (in_run_length == '0) begin
            state_nxt = ST_DONE;
          end else if (in_operation == ffsa_pkg::OP_ALLOC) begin
            if (LW'(in_run_length) <= LW'(free_r)) begin
              state_nxt = ST_SCAN;
            end else begin
              state_nxt = ST_DONE;
            end
          end else if (rel_end <= XW'(POOL_SIZE)) begin
            ok_nxt    = 1'b1;
            state_nxt = ST_UPD_RD;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        rd_addr      = scan_idx_r + 1'b1;
        scan_idx_nxt = scan_idx_r + 1'b1;
        carry_nxt    = scan_carry;
        if (hit != '0) begin
          // The run ends at the first hit; it starts len - 1 slots below.
          hi_nxt    = {scan_idx_r, hit_pos};
          lo_nxt    = PW'(XW'({scan_idx_r, hit_pos}) + XW'(1) - XW'(len_r));
          start_nxt = PW'(XW'({scan_idx_r, hit_pos}) + XW'(1) - XW'(len_r));
          ok_nxt    = 1'b1;
          free_nxt  = CW'(LW'(free_r) - len_r);
          state_nxt = ST_UPD_RD;
        end else if (scan_idx_r == WAW'(WORDS - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_UPD_RD: begin
        rd_addr     = lo_r[PW-1:WB];
        upd_idx_nxt = lo_r[PW-1:WB];
        state_nxt   = ST_UPD_WR;
      end
      ST_UPD_WR: begin
        // Write this word and read the next one; the addresses never coincide.
        we          = 1'b1;
        wa          = upd_idx_r;
        rd_addr     = upd_idx_r + 1'b1;
        upd_idx_nxt = upd_idx_r + 1'b1;
        if (op_r == ffsa_pkg::OP_ALLOC) begin
          wd = rdata_r | upd_mask;
        end else begin
          wd       = rdata_r & ~upd_mask;
          free_nxt = free_r + CW'(popcount(rdata_r & upd_mask));
        end
        if (upd_idx_r == hi_r[PW-1:WB]) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = ok_r;
          out_start_nxt = start_r;
          out_free_nxt  = free_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      free_r      <= CW'(POOL_SIZE);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      free_r      <= free_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_idx_r  <= scan_idx_nxt;
    upd_idx_r   <= upd_idx_nxt;
    op_r        <= op_nxt;
    len_r       <= len_nxt;
    carry_r     <= carry_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    ok_r        <= ok_nxt;
    start_r     <= start_nxt;
    out_ok_r    <= out_ok_nxt;
    out_start_r <= out_start_nxt;
    out_free_r  <= out_free_nxt;
  end

  assign start_ext      = {{ffsa_pkg::SLOT_W{1'b0}}, out_start_r};
  assign free_ext       = {{ffsa_pkg::FREE_W{1'b0}}, out_free_r};
  assign out_valid      = out_valid_r;
  assign out_success    = out_ok_r;
  assign out_start_slot = start_ext[ffsa_pkg::SLOT_W-1:0];
  assign out_free_slots = free_ext[ffsa_pkg::FREE_W-1:0];

  a_free_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    free_r <= CW'(POOL_SIZE))
    else $error("free count exceeds the pool size");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CLEAR |-> !in_ready)
    else $error("request accepted during the clearing pass");

  a_scan_nonzero_len: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> len_r != '0)
    else $error("scan started for a zero-length run");

  a_update_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_UPD_WR |-> (upd_idx_r <= hi_r[PW-1:WB] && lo_r <= hi_r))
    else $error("bitmap update outside the request's run");

  a_fail_zero_start: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DONE && !ok_r |-> start_r == '0)
    else $error("failed request carries a nonzero start slot");

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the first-fit slot allocator with its own bitmap model.
module tb_top;

  localparam int POOL            = ffsa_pkg::POOL_SIZE_DEF;
  localparam int RANDOM_REQUESTS = 1820;
  localparam int QUIET_TAIL      = 300;
  localparam int STALL_LIMIT     = 5000;
  localparam int MAX_REPORTS     = 10;

  typedef struct packed {
    logic                        operation;
    logic [ffsa_pkg::SLOT_W-1:0] slot_index;
    logic [ffsa_pkg::LEN_W-1:0]  run_length;
  } slot_request_t;

  typedef struct packed {
    logic                        success;
    logic [ffsa_pkg::SLOT_W-1:0] start_slot;
    logic [ffsa_pkg::FREE_W-1:0] free_slots;
  } slot_reply_t;

  typedef struct {
    int first;
    int count;
  } slot_run_t;

  logic                        clk            = 1'b0;
  logic                        rst_n          = 1'b0;
  logic                        in_valid       = 1'b0;
  logic                        in_ready;
  logic                        in_operation   = ffsa_pkg::OP_ALLOC;
  logic [ffsa_pkg::SLOT_W-1:0] in_slot_index  = '0;
  logic [ffsa_pkg::LEN_W-1:0]  in_run_length  = '0;
  logic                        out_valid;
  logic                        out_ready      = 1'b0;
  logic                        out_success;
  logic [ffsa_pkg::SLOT_W-1:0] out_start_slot;
  logic [ffsa_pkg::FREE_W-1:0] out_free_slots;

  // Model of the pool: one used mark per slot and the free count.
  bit            model_used [POOL];
  int            model_free = POOL;
  slot_reply_t   expected_replies [$];
  slot_request_t pending_requests [$];
  slot_run_t     live_runs [$];
  int            queued_count   = 0;
  int            accepted_count = 0;
  int            mismatch_count = 0;
  bit            sender_idle    = 1'b1;
  bit            receiver_idle  = 1'b1;

  first_fit_slot_allocator #(
    .POOL_SIZE(POOL)
  ) DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_operation  (in_operation),
    .in_slot_index (in_slot_index),
    .in_run_length (in_run_length),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_success   (out_success),
    .out_start_slot(out_start_slot),
    .out_free_slots(out_free_slots)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int first_fit(int count);
    int run = 0;
    for (int i = 0; i < POOL; i++) begin
      run = model_used[i] ? 0 : run + 1;
      if (run == count) return i + 1 - count;
    end
    return -1;
  endfunction

  function automatic void apply_request(slot_request_t req);
    slot_reply_t reply;
    slot_run_t   taken;
    int          first;
    int          count;
    reply = '0;
    count = int'(req.run_length);
    first = int'(req.slot_index);
    if (req.operation == ffsa_pkg::OP_ALLOC) begin
      first = (count != 0 && count <= model_free) ? first_fit(count) : -1;
      if (first >= 0) begin
        for (int i = first; i < first + count; i++) model_used[i] = 1'b1;
        model_free -= count;
        reply.success    = 1'b1;
        reply.start_slot = ffsa_pkg::SLOT_W'(first);
        taken.first = first;
        taken.count = count;
        live_runs.push_back(taken);
      end
    end else if (count != 0 && first + count <= POOL) begin
      // Only slots that were in use add to the free count.
      for (int i = first; i < first + count; i++) begin
        if (model_used[i]) begin
          model_used[i] = 1'b0;
          model_free++;
        end
      end
      reply.success = 1'b1;
    end
    reply.free_slots = ffsa_pkg::FREE_W'(model_free);
    expected_replies.push_back(reply);
  endfunction

  task automatic queue_request(logic op, int index, int count);
    slot_request_t req;
    req.operation  = op;
    req.slot_index = ffsa_pkg::SLOT_W'(index);
    req.run_length = ffsa_pkg::LEN_W'(count);
    wait (pending_requests.size() < 2);
    pending_requests.push_back(req);
    queued_count++;
  endtask

  task automatic wait_for_drain();
    wait (accepted_count == queued_count && expected_replies.size() == 0);
  endtask

  task automatic queue_random_request(int alloc_weight);
    slot_run_t run;
    int        pick;
    int        first;
    int        count;
    int        k;
    pick = $urandom_range(0, 99);
    if (pick < alloc_weight) begin
      case ($urandom_range(0, 19))
        0:       count = $urandom_range(257, POOL);
        1, 2, 3: count = $urandom_range(33, 256);
        default: count = $urandom_range(1, 32);
      endcase
      queue_request(ffsa_pkg::OP_ALLOC, $urandom_range(0, POOL - 1), count);
    end else if (pick < 85 && live_runs.size() > 0) begin
      k = $urandom_range(0, live_runs.size() - 1);
      run = live_runs[k];
      live_runs.delete(k);
      first = run.first;
      count = run.count;
      // Now and then release a shifted or resized piece of the run.
      if ($urandom_range(0, 4) == 0) begin
        first = first + $urandom_range(0, count - 1);
        count = $urandom_range(1, count + 16);
        if (count > POOL) count = POOL;
      end
      queue_request(ffsa_pkg::OP_RELEASE, first, count);
    end else if (pick < 93) begin
      count = $urandom_range(0, 1) ? $urandom_range(1, POOL) : $urandom_range(1, 64);
      queue_request(ffsa_pkg::OP_RELEASE, $urandom_range(0, POOL - 1), count);
    end else if (pick < 97) begin
      queue_request($urandom_range(0, 1) ? ffsa_pkg::OP_RELEASE : ffsa_pkg::OP_ALLOC,
                    $urandom_range(0, POOL - 1), 0);
    end else begin
      queue_request(ffsa_pkg::OP_ALLOC, $urandom_range(0, POOL - 1),
                    $urandom_range(0, POOL));
    end
  endtask

  // Request driver: holds each request until accepted, with random gaps in between.
  int send_gap = 0;
  always @(posedge clk) begin : request_driver
    slot_request_t next_req;
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && in_ready) begin
        apply_request('{in_operation, in_slot_index, in_run_length});
        accepted_count <= accepted_count + 1;
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (sender_idle && $urandom_range(0, 5) == 0) begin
          send_gap <= $urandom_range(0, 14);
          in_valid <= 1'b0;
        end else if (pending_requests.size() > 0) begin
          next_req = pending_requests.pop_front();
          in_valid      <= 1'b1;
          in_operation  <= next_req.operation;
          in_slot_index <= next_req.slot_index;
          in_run_length <= next_req.run_length;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Reply monitor with random back-pressure and a watchdog on stalled traffic.
  int stall_left   = 0;
  int quiet_cycles = 0;
  always @(posedge clk) begin : reply_monitor
    slot_reply_t want;
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_replies.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("Unexpected reply: success=%0d start=%0d free=%0d",
                     out_success, out_start_slot, out_free_slots);
        end else begin
          want = expected_replies.pop_front();
          if (out_success !== want.success || out_start_slot !== want.start_slot ||
              out_free_slots !== want.free_slots) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display("Reply mismatch: expected success=%0d start=%0d free=%0d, got %0d %0d %0d",
                       want.success, want.start_slot, want.free_slots,
                       out_success, out_start_slot, out_free_slots);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ready  <= 1'b0;
      end else if (receiver_idle && $urandom_range(0, 7) == 0) begin
        stall_left <= $urandom_range(0, 14);
        out_ready  <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int alloc_weight;
    alloc_weight = 50;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    queue_request(ffsa_pkg::OP_ALLOC, 0, 0);
    queue_request(ffsa_pkg::OP_RELEASE, 5, 0);
    queue_request(ffsa_pkg::OP_ALLOC, POOL - 1, 1);
    queue_request(ffsa_pkg::OP_ALLOC, 0, POOL);
    queue_request(ffsa_pkg::OP_RELEASE, 0, 1);
    queue_request(ffsa_pkg::OP_ALLOC, 0, POOL);
    queue_request(ffsa_pkg::OP_ALLOC, 0, 1);
    queue_request(ffsa_pkg::OP_RELEASE, POOL - 1, 1);
    queue_request(ffsa_pkg::OP_RELEASE, POOL - 1, 2);
    queue_request(ffsa_pkg::OP_RELEASE, POOL - 1, 1);
    queue_request(ffsa_pkg::OP_RELEASE, POOL - 1, POOL);
    queue_request(ffsa_pkg::OP_RELEASE, 0, POOL);
    queue_request(ffsa_pkg::OP_RELEASE, 0, POOL);
    // Two holes of a quarter pool each: enough free slots in total, but no run fits.
    queue_request(ffsa_pkg::OP_ALLOC, POOL - 1, POOL / 2);
    queue_request(ffsa_pkg::OP_ALLOC, 0, POOL / 2);
    queue_request(ffsa_pkg::OP_RELEASE, POOL / 4, POOL / 4);
    queue_request(ffsa_pkg::OP_RELEASE, 3 * POOL / 4, POOL / 4);
    queue_request(ffsa_pkg::OP_ALLOC, 0, POOL / 4 + 88);
    queue_request(ffsa_pkg::OP_ALLOC, 0, POOL / 4);
    queue_request(ffsa_pkg::OP_RELEASE, POOL / 2 + 1, POOL / 2);
    queue_request(ffsa_pkg::OP_RELEASE, 1, POOL - 1);
    queue_request(ffsa_pkg::OP_ALLOC, 0, 100);
    queue_request(ffsa_pkg::OP_ALLOC, 0, 50);
    queue_request(ffsa_pkg::OP_RELEASE, 1, 100);
    queue_request(ffsa_pkg::OP_ALLOC, 0, 120);
    queue_request(ffsa_pkg::OP_ALLOC, 0, 100);
    queue_request(ffsa_pkg::OP_RELEASE, 0, POOL);
    wait_for_drain();
    live_runs.delete();

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 100 == 0) begin
        alloc_weight  = $urandom_range(25, 70);
        sender_idle   = ($urandom_range(0, 3) != 0);
        receiver_idle = ($urandom_range(0, 3) != 0);
      end
      if (n == RANDOM_REQUESTS / 2) wait_for_drain();
      if (n >= RANDOM_REQUESTS - QUIET_TAIL) begin
        sender_idle   = 1'b0;
        receiver_idle = 1'b0;
      end
      queue_random_request(alloc_weight);
    end

    wait_for_drain();
    repeat (300) @(posedge clk);
    if (mismatch_count == 0 && expected_replies.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
